### rtl/psg_pkg.sv
// Shared types, constants and the volume amplitude table for the sound generator.
`default_nettype none

package psg_pkg;

  // Item opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Field and state widths
  localparam int DEC_W    = 23;
  localparam int DIV_W    = 11;
  localparam int VOL_W    = 4;
  localparam int LFSR_W   = 15;
  localparam int NCTL_W   = 3;
  localparam int LATCH_W  = 3;
  localparam int AMP_W    = 13;
  localparam int SAMPLE_W = 16;
  localparam int MIX_W    = SAMPLE_W + 1;
  localparam int TONES    = 3;
  localparam int CHANNELS = 4;

  // Reset and special values
  localparam logic [DEC_W-1:0]  DEC_RESET  = 23'd23220;
  localparam logic [DIV_W-1:0]  DIV_RESET  = 11'd1024;
  localparam logic [VOL_W-1:0]  VOL_SILENT = 4'd15;
  localparam logic [LFSR_W-1:0] LFSR_SEED  = 15'h4000;

  // Register select in a latch byte
  localparam logic [1:0] CH_NOISE = 2'd3;

  // Noise rate select (control bits 1..0)
  localparam logic [1:0] NRATE_16  = 2'd0;
  localparam logic [1:0] NRATE_32  = 2'd1;
  localparam logic [1:0] NRATE_64  = 2'd2;
  localparam logic [DIV_W-1:0] NRELOAD_16 = 11'd16;
  localparam logic [DIV_W-1:0] NRELOAD_32 = 11'd32;
  localparam logic [DIV_W-1:0] NRELOAD_64 = 11'd64;

  // Mix saturation limits
  localparam logic signed [MIX_W-1:0] MIX_MAX = 17'sd32767;
  localparam logic signed [MIX_W-1:0] MIX_MIN = -17'sd32768;

  typedef logic signed [AMP_W:0] term_t;

  // Amplitude per volume step, about 2 dB per step, last step silent
  function automatic logic [AMP_W-1:0] amp_lookup(input logic [VOL_W-1:0] vol);
    logic [AMP_W-1:0] a;
    case (vol)
      4'd0:    a = 13'd4096;
      4'd1:    a = 13'd3253;
      4'd2:    a = 13'd2584;
      4'd3:    a = 13'd2053;
      4'd4:    a = 13'd1631;
      4'd5:    a = 13'd1295;
      4'd6:    a = 13'd1029;
      4'd7:    a = 13'd817;
      4'd8:    a = 13'd649;
      4'd9:    a = 13'd516;
      4'd10:   a = 13'd410;
      4'd11:   a = 13'd325;
      4'd12:   a = 13'd258;
      4'd13:   a = 13'd205;
      4'd14:   a = 13'd163;
      default: a = 13'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### rtl/psg_tone_noise_generator.sv
// Three-tone, one-noise sound generator: register decode, channel counters and mixer.
//
// Input channel (in_valid / in_stall): each transfer carries an opcode and a byte.
// A write item (opcode 0) updates the tone, volume or noise registers and makes no
// result. A sample item (opcode 1) steps all four channel counters once and makes
// one signed 16-bit sample on the output channel (out_valid / out_stall).
// Configuration (cfg_valid / cfg_ready / cfg_data) sets the per-sample counter
// decrement; cfg_ready is always high, and the user must write it only while idle,
// which the block itself does not enforce.
// A sample passes the channel update register, then the mixer/output register,
// before it appears on out_sample. One item per cycle is taken sustained while
// in_stall is low; the channel state updates in the cycle of acceptance, so the
// next item sees it at once.
// Reset (synchronous, rst_n low): dividers 1024, volumes silent, counters and
// output bits zero, noise control zero, noise shift register 0x4000, decrement
// 23220, pipeline empty.
// Stall: a held output keeps its sample; the stage behind it still fills, and only
// when both are full does in_stall rise, in the same cycle as out_stall.
`default_nettype none

module psg_tone_noise_generator #(
  parameter int FRACTION_BITS = 12
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_opcode,
  input  wire logic [7:0]                     in_write_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [psg_pkg::SAMPLE_W-1:0] out_sample,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [psg_pkg::DEC_W-1:0]      cfg_data
);

  import psg_pkg::*;

  // Counter holds up to 1024 whole units; subtract works in a signed word wide
  // enough for counter, decrement and reload.
  localparam int CW = FRACTION_BITS + DIV_W;
  localparam int SW = ((CW > DEC_W) ? CW : DEC_W) + 2;

  // State
  logic [DEC_W-1:0]  dec_r;
  logic [DIV_W-1:0]  div_r  [TONES];
  logic [DIV_W-1:0]  div_nxt[TONES];
  logic [VOL_W-1:0]  vol_r  [CHANNELS];
  logic [VOL_W-1:0]  vol_nxt[CHANNELS];
  logic [CW-1:0]     cnt_r  [CHANNELS];
  logic [CW-1:0]     cnt_nxt[CHANNELS];
  logic [TONES-1:0]  tbit_r, tbit_nxt;
  logic [NCTL_W-1:0] nctl_r, nctl_nxt;
  logic [LFSR_W-1:0] lfsr_r, lfsr_nxt;
  logic [LATCH_W-1:0] latch_r, latch_nxt;

  // Pipeline
  logic              s1_valid_r;
  term_t             term_r[CHANNELS];
  term_t             term_nxt[CHANNELS];
  logic              out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic signed [MIX_W-1:0]    mix;

  logic out_load, in_acc, tick_acc, wr_acc;
  logic [DIV_W-1:0] reload[CHANNELS];
  logic [CHANNELS-1:0] toggle;

  // Flow control: output register loads when empty or drained
  assign out_load  = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_load;
  assign in_acc    = in_valid && !in_stall;
  assign tick_acc  = in_acc && (in_opcode == OP_SAMPLE);
  assign wr_acc    = in_acc && (in_opcode == OP_WRITE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_sample = out_sample_r;

  // Reload amount per channel; noise picks a fixed rate or tone 2
  always_comb begin
    for (int i = 0; i < TONES; i++) begin
      reload[i] = div_r[i];
    end
    case (nctl_r[1:0])
      NRATE_16: reload[CHANNELS-1] = NRELOAD_16;
      NRATE_32: reload[CHANNELS-1] = NRELOAD_32;
      NRATE_64: reload[CHANNELS-1] = NRELOAD_64;
      default:  reload[CHANNELS-1] = div_r[TONES-1];
    endcase
  end

  // Channel counters: subtract, on underflow add reload, clamp at zero, toggle
  always_comb begin
    logic signed [SW-1:0] diff;
    logic signed [SW-1:0] back;
    for (int i = 0; i < CHANNELS; i++) begin
      diff = $signed({{(SW-CW){1'b0}}, cnt_r[i]}) - $signed({{(SW-DEC_W){1'b0}}, dec_r});
      back = diff + $signed({{(SW-DIV_W){1'b0}}, reload[i]} << FRACTION_BITS);
      toggle[i] = diff[SW-1];
      if (!diff[SW-1]) begin
        cnt_nxt[i] = diff[CW-1:0];
      end else if (back[SW-1]) begin
        cnt_nxt[i] = '0;
      end else begin
        cnt_nxt[i] = back[CW-1:0];
      end
    end
  end

  // Tick: new tone bits, noise shift, signed amplitude terms
  always_comb begin
    logic fb;
    logic [AMP_W-1:0] amp;
    logic [CHANNELS-1:0] pos;
    fb = nctl_r[2] ? (lfsr_r[0] ^ lfsr_r[1]) : lfsr_r[0];
    tbit_nxt = tbit_r ^ toggle[TONES-1:0];
    lfsr_nxt = toggle[CHANNELS-1] ? {fb, lfsr_r[LFSR_W-1:1]} : lfsr_r;
    // tones use their output bit, noise uses shift register bit 0
    pos = {lfsr_nxt[0], tbit_nxt};
    for (int i = 0; i < CHANNELS; i++) begin
      amp = amp_lookup(vol_r[i]);
      if (pos[i]) begin
        term_nxt[i] = $signed({1'b0, amp});
      end else begin
        term_nxt[i] = -$signed({1'b0, amp});
      end
    end
  end

  // Register write decode: latch bytes and data bytes
  always_comb begin
    logic [1:0] ch;
    logic       isvol;
    logic [DIV_W-1:0] v;
    v = '0;
    for (int i = 0; i < TONES; i++) begin
      div_nxt[i] = div_r[i];
    end
    for (int i = 0; i < CHANNELS; i++) begin
      vol_nxt[i] = vol_r[i];
    end
    nctl_nxt  = nctl_r;
    latch_nxt = latch_r;
    ch    = in_write_byte[7] ? in_write_byte[6:5] : latch_r[2:1];
    isvol = in_write_byte[7] ? in_write_byte[4] : latch_r[0];
    if (in_write_byte[7]) begin
      latch_nxt = {ch, isvol};
    end
    if (isvol) begin
      // data byte after a volume latch does nothing
      if (in_write_byte[7]) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (ch == i[1:0]) vol_nxt[i] = in_write_byte[3:0];
        end
      end
    end else if (ch == CH_NOISE) begin
      nctl_nxt = in_write_byte[NCTL_W-1:0];
    end else begin
      for (int i = 0; i < TONES; i++) begin
        if (ch == i[1:0]) begin
          if (in_write_byte[7]) begin
            v = {1'b0, div_r[i][9:4], in_write_byte[3:0]};
          end else begin
            v = {1'b0, in_write_byte[5:0], div_r[i][3:0]};
          end
          div_nxt[i] = (v == '0) ? DIV_RESET : v;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r   <= DEC_RESET;
      tbit_r  <= '0;
      nctl_r  <= '0;
      lfsr_r  <= LFSR_SEED;
      latch_r <= '0;
      for (int i = 0; i < TONES; i++) begin
        div_r[i] <= DIV_RESET;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        vol_r[i] <= VOL_SILENT;
        cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        dec_r <= cfg_data;
      end
      if (tick_acc) begin
        tbit_r <= tbit_nxt;
        lfsr_r <= lfsr_nxt;
        for (int i = 0; i < CHANNELS; i++) begin
          cnt_r[i] <= cnt_nxt[i];
        end
      end
      if (wr_acc) begin
        latch_r <= latch_nxt;
        nctl_r  <= nctl_nxt;
        if (!in_write_byte[7] ? (!latch_r[0] && latch_r[2:1] == CH_NOISE)
                              : (!in_write_byte[4] && in_write_byte[6:5] == CH_NOISE)) begin
          lfsr_r <= LFSR_SEED;
        end
        for (int i = 0; i < TONES; i++) begin
          div_r[i] <= div_nxt[i];
        end
        for (int i = 0; i < CHANNELS; i++) begin
          vol_r[i] <= vol_nxt[i];
        end
      end
    end
  end

  // Stage 1: amplitude terms of the ticked sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (tick_acc) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      for (int i = 0; i < CHANNELS; i++) begin
        term_r[i] <= term_nxt[i];
      end
    end
  end

  // Stage 2: mix, saturate, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_comb begin
    mix = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      mix = mix + MIX_W'(term_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      if (mix > MIX_MAX) begin
        out_sample_r <= MIX_MAX[SAMPLE_W-1:0];
      end else if (mix < MIX_MIN) begin
        out_sample_r <= MIX_MIN[SAMPLE_W-1:0];
      end else begin
        out_sample_r <= mix[SAMPLE_W-1:0];
      end
    end
  end

  // Checks
  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0) else $error("noise shift register reached zero");

  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    (div_r[0] != '0) && (div_r[1] != '0) && (div_r[2] != '0) &&
    (div_r[0] <= DIV_RESET) && (div_r[1] <= DIV_RESET) && (div_r[2] <= DIV_RESET))
    else $error("tone divider out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r)) else $error("stall with free stage");

  a_tick_enters: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> s1_valid_r) else $error("accepted tick lost");

endmodule

`default_nettype wire
